### rtl/apse_pkg.sv
package apse_pkg;

  localparam int unsigned MaxGroup = 4;

  localparam logic [7:0] ByteZero    = 8'h00;
  localparam logic [7:0] ByteOne     = 8'h01;
  localparam logic [4:0] NalTypeSps  = 5'd7;
  localparam logic [4:0] NalTypePps  = 5'd8;

  typedef enum logic [1:0] {
    MODE_SEARCH = 2'd0,
    MODE_HEADER = 2'd1,
    MODE_BODY   = 2'd2,
    MODE_DONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_SPS   = 2'd1,
    KIND_PPS   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_end;
    logic       packet_keyframe;
  } in_item_t;

  typedef struct packed {
    logic [7:0] nal_byte;
    logic       nal_kind;
    logic       nal_final;
    logic       sets_captured;
  } out_item_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [MaxGroup-1:0][7:0] bytes;
    logic [2:0]               count;
    logic                     kind_pps;
    logic                     last_final;
    logic                     last_captured;
  } group_t;

endpackage

### rtl/apse_front.sv
module apse_front import apse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output group_t   grp_o
);

  mode_e      mode_q, mode_d;
  kind_e      kind_q, kind_d;
  logic [1:0] zr_q, zr_d;
  logic [7:0] held_q, held_d;
  logic [1:0] hz_q, hz_d;
  logic       sps_q, sps_d;
  logic       pps_q, pps_d;
  logic       cap_q, cap_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SEARCH;
      kind_q <= KIND_OTHER;
      zr_q   <= '0;
      held_q <= '0;
      hz_q   <= '0;
      sps_q  <= 1'b0;
      pps_q  <= 1'b0;
      cap_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      kind_q <= kind_d;
      zr_q   <= zr_d;
      held_q <= held_d;
      hz_q   <= hz_d;
      sps_q  <= sps_d;
      pps_q  <= pps_d;
      cap_q  <= cap_d;
    end
  end

  always_comb begin
    logic [7:0] b;
    logic       pend;
    logic       key;
    logic       do_close;
    logic [7:0] c_held;
    logic [1:0] c_hz;
    logic [1:0] c_zr;
    kind_e      c_kind;
    kind_e      emit_kind;
    kind_e      hdr_kind;
    logic [2:0] n;
    logic       last_fin;
    logic       last_cap;
    logic [MaxGroup-1:0][7:0] bytes;

    b        = item_i.data_byte;
    pend     = item_i.packet_end;
    key      = item_i.packet_keyframe;
    mode_d   = mode_q;
    kind_d   = kind_q;
    zr_d     = zr_q;
    held_d   = held_q;
    hz_d     = hz_q;
    sps_d    = sps_q;
    pps_d    = pps_q;
    cap_d    = cap_q;
    do_close = 1'b0;
    c_held   = held_q;
    c_hz     = hz_q;
    c_zr     = 2'd0;
    c_kind   = kind_q;
    emit_kind = kind_q;
    n        = 3'd0;
    last_fin = 1'b0;
    last_cap = 1'b0;
    bytes    = '0;

    case (b[4:0])
      NalTypeSps: hdr_kind = KIND_SPS;
      NalTypePps: hdr_kind = KIND_PPS;
      default:    hdr_kind = KIND_OTHER;
    endcase

    if (accept_i && mode_q != MODE_DONE) begin
      if (!key) begin
        if (pend) begin
          if (mode_q == MODE_BODY) begin
            do_close = 1'b1;
          end else begin
            mode_d = MODE_SEARCH;
            zr_d   = 2'd0;
          end
        end
      end else begin
        case (mode_q)
          MODE_SEARCH: begin
            if (b == ByteZero) begin
              if (zr_q != 2'd3) zr_d = zr_q + 2'd1;
            end else if (b == ByteOne && zr_q == 2'd3) begin
              mode_d = MODE_HEADER;
              zr_d   = 2'd0;
            end else begin
              zr_d = 2'd0;
            end
            if (pend) begin
              mode_d = MODE_SEARCH;
              zr_d   = 2'd0;
            end
          end
          MODE_HEADER: begin
            kind_d    = hdr_kind;
            held_d    = b;
            hz_d      = 2'd0;
            mode_d    = MODE_BODY;
            emit_kind = hdr_kind;
            if (pend) begin
              do_close = 1'b1;
              c_held   = b;
              c_hz     = 2'd0;
              c_kind   = hdr_kind;
            end
          end
          MODE_BODY: begin
            if (hz_q >= 2'd2 && b <= ByteOne) begin
              // zeros after the held byte open the next start code
              do_close = 1'b1;
              c_hz     = 2'd0;
              c_zr     = (b == ByteZero && !pend) ? 2'd3 : 2'd0;
            end else if (b == ByteZero) begin
              if (pend) begin
                do_close = 1'b1;
                c_hz     = hz_q + 2'd1;
              end else begin
                hz_d = hz_q + 2'd1;
              end
            end else begin
              bytes[n[1:0]] = held_q;
              n = n + 3'd1;
              if (hz_q >= 2'd1) begin
                bytes[n[1:0]] = ByteZero;
                n = n + 3'd1;
              end
              if (hz_q >= 2'd2) begin
                bytes[n[1:0]] = ByteZero;
                n = n + 3'd1;
              end
              if (pend) begin
                do_close = 1'b1;
                c_held   = b;
                c_hz     = 2'd0;
              end else begin
                held_d = b;
                hz_d   = 2'd0;
              end
            end
          end
          default: ;
        endcase
      end
    end

    if (do_close) begin
      bytes[n[1:0]] = c_held;
      n = n + 3'd1;
      if (c_hz >= 2'd1) begin
        bytes[n[1:0]] = ByteZero;
        n = n + 3'd1;
      end
      if (c_hz >= 2'd2) begin
        bytes[n[1:0]] = ByteZero;
        n = n + 3'd1;
      end
      if (c_kind == KIND_SPS) sps_d = 1'b1;
      if (c_kind == KIND_PPS) pps_d = 1'b1;
      cap_d    = sps_d && pps_d;
      last_fin = 1'b1;
      last_cap = cap_d;
      mode_d   = cap_d ? MODE_DONE : MODE_SEARCH;
      zr_d     = cap_d ? 2'd0 : c_zr;
      kind_d   = KIND_OTHER;
      held_d   = '0;
      hz_d     = 2'd0;
    end

    grp_o.bytes         = bytes;
    grp_o.count         = (emit_kind == KIND_OTHER) ? 3'd0 : n;
    grp_o.kind_pps      = (emit_kind == KIND_PPS);
    grp_o.last_final    = last_fin;
    grp_o.last_captured = last_cap;
  end

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_DONE) |-> (grp_o.count == 3'd0))
    else $error("results produced after capture");

  a_cap_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_q |=> (cap_q && mode_q == MODE_DONE))
    else $error("capture flag or done mode lost");

endmodule

### rtl/apse_queue.sv
module apse_queue import apse_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  group_t wdata_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   rvalid_o,
  output group_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  group_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o   = (cnt_q == CntW'(Depth));
  assign rvalid_o = (cnt_q != '0);
  assign rdata_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> rvalid_o)
    else $error("queue pop while empty");

endmodule

### rtl/apse_back.sv
module apse_back import apse_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  group_t    q_data_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  group_t     grp_q, grp_d;
  logic       grp_valid_q, grp_valid_d;
  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;

  logic load_out;
  logic last_elem;
  logic take_grp;

  assign load_out  = grp_valid_q && (!out_valid_q || !out_stall_i);
  assign last_elem = ({1'b0, idx_q} == (grp_q.count - 3'd1));
  assign take_grp  = !grp_valid_q || (load_out && last_elem);
  assign q_pop_o   = take_grp && q_valid_i;

  always_comb begin
    grp_d       = grp_q;
    grp_valid_d = grp_valid_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load_out) begin
      out_valid_d         = 1'b1;
      out_d.nal_byte      = grp_q.bytes[idx_q];
      out_d.nal_kind      = grp_q.kind_pps;
      out_d.nal_final     = grp_q.last_final && last_elem;
      out_d.sets_captured = grp_q.last_captured && last_elem;
      idx_d               = idx_q + 2'd1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (take_grp) begin
      grp_valid_d = q_valid_i;
      grp_d       = q_data_i;
      idx_d       = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      grp_valid_q <= grp_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_group_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_valid_q |-> (grp_q.count != 3'd0 && grp_q.count <= 3'(MaxGroup)))
    else $error("empty or oversized group in serializer");

endmodule

### rtl/annexb_parameter_set_extractor.sv
// channel | direction | handshake          | payload
// in      | input     | in_valid_i/in_stall_o  | in_data_i  (byte, packet end, keyframe)
// out     | output    | out_valid_o/out_stall_i | out_data_o (byte, kind, final, captured)
//
// one input byte is accepted per cycle while the group queue has room
// a byte causes zero to four result bytes; the output register sends one per
// cycle while out_stall_i is low, so the k results of one byte go out in turn
// the front parser and the output serializer are parted by a QueueDepth-group queue
// asynchronous reset returns the parser to start code search; no clearing pass
// in_stall_o rises only when the queue is full, independent of in_valid_i
module annexb_parameter_set_extractor import apse_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic   accept;
  logic   push;
  logic   q_full;
  logic   q_valid;
  logic   q_pop;
  group_t grp;
  group_t q_data;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !in_stall_o;
  assign push       = accept && (grp.count != 3'd0);

  apse_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .grp_o    (grp)
  );

  apse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (grp),
    .full_o   (q_full),
    .pop_i    (q_pop),
    .rvalid_o (q_valid),
    .rdata_o  (q_data)
  );

  apse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_captured_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.sets_captured) |-> out_data_o.nal_final)
    else $error("capture mark on a non-final byte");

endmodule

### test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import apse_pkg::*;

  localparam int StallLimit = 1000;

  // tracks the parser state and holds the parameter set bytes still owed
  class ps_scoreboard;
    mode_e      mode = MODE_SEARCH;
    logic [1:0] zero_run = '0;
    kind_e      kind = KIND_OTHER;
    logic [7:0] held_byte = '0;
    logic       held_valid = 1'b0;
    logic [1:0] held_zeros = '0;
    logic       sps_seen = 1'b0;
    logic       pps_seen = 1'b0;
    logic       captured = 1'b0;
    out_item_t  expected_nal[$];
    int         errors = 0;

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function bit header_next();
      return mode == MODE_HEADER && !captured;
    endfunction

    function void emit(logic [7:0] b, logic fin);
      out_item_t r;
      if (kind == KIND_OTHER) return;
      r.nal_byte      = b;
      r.nal_kind      = (kind == KIND_PPS);
      r.nal_final     = fin;
      r.sets_captured = captured;
      expected_nal.push_back(r);
    endfunction

    // flush the held byte and held zeros, the last one marked final
    function void close_unit();
      int count;
      count = int'(held_valid) + int'(held_zeros);
      for (int i = 0; i + 1 < count; i++)
        emit((i == 0 && held_valid) ? held_byte : ByteZero, 1'b0);
      if (count > 0) begin
        if (kind == KIND_SPS) sps_seen = 1'b1;
        else if (kind == KIND_PPS) pps_seen = 1'b1;
        if (sps_seen && pps_seen) captured = 1'b1;
        emit((count == 1 && held_valid) ? held_byte : ByteZero, 1'b1);
      end
      held_byte  = '0;
      held_valid = 1'b0;
      held_zeros = '0;
      kind       = KIND_OTHER;
      zero_run   = '0;
      mode       = captured ? MODE_DONE : MODE_SEARCH;
    endfunction

    function void end_packet();
      if (mode == MODE_BODY) close_unit();
      if (mode != MODE_DONE) begin
        mode     = MODE_SEARCH;
        zero_run = '0;
      end
    endfunction

    function void parse_byte(in_item_t it);
      logic [7:0] b;
      logic [4:0] t;
      b = it.data_byte;
      if (captured || mode == MODE_DONE) return;
      if (!it.packet_keyframe) begin
        if (it.packet_end) end_packet();
        return;
      end
      case (mode)
        MODE_SEARCH: begin
          if (b == ByteZero) begin
            if (zero_run != 2'd3) zero_run++;
          end else if (b == ByteOne && zero_run == 2'd3) begin
            mode     = MODE_HEADER;
            zero_run = '0;
          end else begin
            zero_run = '0;
          end
        end
        MODE_HEADER: begin
          t          = b[4:0];
          kind       = (t == NalTypeSps) ? KIND_SPS : (t == NalTypePps) ? KIND_PPS : KIND_OTHER;
          held_byte  = b;
          held_valid = 1'b1;
          held_zeros = '0;
          mode       = MODE_BODY;
        end
        default: begin
          if (held_zeros >= 2 && b <= ByteOne) begin
            // two held zeros plus this byte form the terminator
            held_zeros = '0;
            close_unit();
            if (mode == MODE_SEARCH) zero_run = (b == ByteZero) ? 2'd3 : 2'd0;
          end else if (b == ByteZero) begin
            held_zeros++;
          end else begin
            if (held_valid) emit(held_byte, 1'b0);
            for (int i = 0; i < held_zeros; i++) emit(ByteZero, 1'b0);
            held_byte  = b;
            held_valid = 1'b1;
            held_zeros = '0;
          end
        end
      endcase
      if (it.packet_end) end_packet();
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_nal.size() == 0) begin
        report($sformatf("unexpected result byte %02h", got.nal_byte));
        return;
      end
      want = expected_nal.pop_front();
      if (got.nal_byte !== want.nal_byte)
        report($sformatf("nal_byte got %02h want %02h", got.nal_byte, want.nal_byte));
      if (got.nal_kind !== want.nal_kind)
        report($sformatf("nal_kind got %b want %b", got.nal_kind, want.nal_kind));
      if (got.nal_final !== want.nal_final)
        report($sformatf("nal_final got %b want %b", got.nal_final, want.nal_final));
      if (got.sets_captured !== want.sets_captured)
        report($sformatf("sets_captured got %b want %b", got.sets_captured,
                         want.sets_captured));
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  ps_scoreboard sb = new;
  logic         calm = 1'b0;
  logic         keep_open = 1'b1;
  logic [4:0]   main_type;
  logic [4:0]   closing_type;
  int           bytes_sent = 0;

  annexb_parameter_set_extractor u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #5ns clk = ~clk;

  function automatic int idle_draw();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic logic [7:0] make_header(bit want_main);
    logic [4:0] t;
    t = main_type;
    if (!want_main) begin
      do t = 5'($urandom_range(0, 31)); while (t == NalTypeSps || t == NalTypePps);
    end
    return {3'($urandom_range(0, 7)), t};
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic pend, input logic key);
    int       gap;
    in_item_t it;
    gap = idle_draw();
    // keep the pair from completing until the closing packet
    if (keep_open && key && sb.header_next() && b[4:0] == closing_type) b[4] = ~b[4];
    it = '{data_byte: b, packet_end: pend, packet_keyframe: key};
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.parse_byte(it);
    bytes_sent++;
  endtask

  task automatic send_packet(input logic [7:0] pkt[$], input logic key, input logic pend_last);
    foreach (pkt[i]) send_byte(pkt[i], pend_last && (i == pkt.size() - 1), key);
  endtask

  task automatic send_random_packet();
    logic [7:0] pkt[$];
    logic       key;
    logic       pend_last;
    int         nz;
    int         r;
    int         cut;
    key       = ($urandom_range(0, 5) != 0);
    pend_last = ($urandom_range(0, 7) != 0);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4)) pkt.push_back(8'($urandom_range(0, 255)));
    repeat ($urandom_range(1, 3)) begin
      // mostly proper start codes, now and then a short one
      nz = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 5);
      repeat (nz) pkt.push_back(ByteZero);
      pkt.push_back(ByteOne);
      pkt.push_back(make_header($urandom_range(0, 2) != 0));
      repeat ($urandom_range(0, 10)) begin
        r = $urandom_range(0, 9);
        pkt.push_back(r < 4 ? ByteZero : r == 4 ? ByteOne : r == 5 ? 8'h03 :
                      8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, pkt.size());
      while (pkt.size() > cut) void'(pkt.pop_back());
    end
    send_packet(pkt, key, pend_last);
  endtask

  // results
  always @(posedge clk) begin
    if (out_valid && !out_stall) sb.check_result(out_data);
  end

  initial begin
    forever begin
      repeat ($urandom_range(40, 200)) @(posedge clk);
      calm <= ($urandom_range(0, 3) == 0);
    end
  end

  // receiver: stall a drawn number of cycles before each transaction
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      n = idle_draw();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    @(posedge rst_n);
    while (idle < StallLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin
    logic [7:0] pkt[$];
    logic [7:0] hdr;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one kind repeats all run long, the other completes the pair at the end
    if ($urandom_range(0, 1) == 0) begin
      main_type    = NalTypeSps;
      closing_type = NalTypePps;
    end else begin
      main_type    = NalTypePps;
      closing_type = NalTypeSps;
    end

    // unit ended by 00 00 00, other unit, start code on the final byte
    hdr = {3'b011, main_type};
    pkt = {8'h00, 8'h00, 8'h00, 8'h01, hdr, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'hE5,
           8'h00, 8'h00, 8'h00, 8'h01};
    send_packet(pkt, 1'b1, 1'b1);
    // 00 00 02 inside the unit, held zeros at packet end
    hdr = {3'b100, main_type};
    pkt = {8'h00, 8'h00, 8'h00, 8'h01, hdr, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00};
    send_packet(pkt, 1'b1, 1'b1);
    // unit cut short by a non-keyframe packet end
    pkt = {8'h00, 8'h00, 8'h00, 8'h01, hdr, 8'h00};
    send_packet(pkt, 1'b1, 1'b0);
    send_byte(8'h55, 1'b1, 1'b0);

    while (bytes_sent < 285) send_random_packet();

    // closing packet completes the pair
    keep_open = 1'b0;
    send_byte(ByteZero, 1'b1, 1'b0);
    pkt = {8'h00, 8'h00, 8'h00, 8'h01, {3'($urandom_range(0, 7)), closing_type}};
    repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom_range(2, 255)));
    send_packet(pkt, 1'b1, 1'b1);
    // ignored after capture
    repeat (10) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
    in_valid <= 1'b0;

    while (sb.expected_nal.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule

### files.f
rtl/apse_pkg.sv
rtl/apse_front.sv
rtl/apse_queue.sv
rtl/apse_back.sv
rtl/annexb_parameter_set_extractor.sv
test/testbench.sv
